>>> rtl/core/sdbw_pkg.sv
// shared types, constants and arithmetic helpers for the segment display bus writer
package sdbw_pkg;

    localparam int DIGIT_COUNT = 4;
    localparam int BYTE_COUNT  = DIGIT_COUNT + 3;

    typedef logic [DIGIT_COUNT-1:0][7:0] t_seg_word;

    // request modes
    localparam logic [1:0] MODE_RAW    = 2'd0;
    localparam logic [1:0] MODE_NUMBER = 2'd1;
    localparam logic [1:0] MODE_TIME   = 2'd2;
    localparam logic [1:0] MODE_FAULT  = 2'd3;

    // configuration register indexes
    localparam logic [7:0] CFG_BRIGHTNESS = 8'd0;
    localparam logic [7:0] CFG_DATA_CMD   = 8'd1;
    localparam logic [7:0] CFG_ADDR_CMD   = 8'd2;
    localparam logic [7:0] CFG_DISP_CMD   = 8'd3;

    // position of a byte within one update
    localparam logic [2:0] IDX_DATA_CMD = 3'd0;
    localparam logic [2:0] IDX_ADDR_CMD = 3'd1;
    localparam logic [2:0] IDX_SEG0     = 3'd2;
    localparam logic [2:0] IDX_SEG1     = 3'd3;
    localparam logic [2:0] IDX_SEG2     = 3'd4;
    localparam logic [2:0] IDX_SEG3     = 3'd5;
    localparam logic [2:0] IDX_DISP_CMD = 3'd6;

    localparam logic [7:0] DISP_ON_BIT = 8'h08;
    localparam logic [7:0] COLON_BIT   = 8'h80;

    localparam t_seg_word FAULT_PATTERN = {8'h38, 8'h3E, 8'h77, 8'h71};
    localparam t_seg_word BLANK_CACHE   = {8'hFF, 8'hFF, 8'hFF, 8'hFF};

    typedef struct packed {
        logic [2:0] brightness;
        logic [7:0] set_data_command;
        logic [7:0] address_command;
        logic [7:0] display_command;
    } t_cfg;

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } t_back_state;

    // x / 10 for any 16-bit x, result fits 13 bits
    function automatic logic [12:0] div10_u16(input logic [15:0] x);
        logic [31:0] p;
        p = 32'(x) * 32'd52429;
        return p[31:19];
    endfunction

    // x / 10 for any 8-bit x
    function automatic logic [4:0] div10_u8(input logic [7:0] x);
        logic [15:0] p;
        p = 16'(x) * 16'd205;
        return p[15:11];
    endfunction

    // x % 10 for x up to 68
    function automatic logic [3:0] mod10_small(input logic [6:0] x);
        logic [9:0] p;
        logic [6:0] r;
        p = 10'(x) * 10'd13;
        r = x - 7'(p[9:7]) * 7'd10;
        return r[3:0];
    endfunction

    function automatic logic [7:0] digit_glyph(input logic [3:0] d);
        logic [7:0] g;
        case (d)
            4'd0:    g = 8'h3F;
            4'd1:    g = 8'h06;
            4'd2:    g = 8'h5B;
            4'd3:    g = 8'h4F;
            4'd4:    g = 8'h66;
            4'd5:    g = 8'h6D;
            4'd6:    g = 8'h7D;
            4'd7:    g = 8'h07;
            4'd8:    g = 8'h7F;
            4'd9:    g = 8'h6F;
            default: g = 8'h00;
        endcase
        return g;
    endfunction

endpackage

>>> rtl/core/sdbw_front.sv
// request front end: accepts requests and forms the four segment bytes in a short pipeline
module sdbw_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [1:0]             i_mode,
    input  logic [7:0]             i_seg0,
    input  logic [7:0]             i_seg1,
    input  logic [7:0]             i_seg2,
    input  logic [7:0]             i_seg3,
    input  logic [15:0]            i_value,
    input  logic [7:0]             i_minutes,
    input  logic [7:0]             i_seconds,
    input  logic                   i_colon,
    output logic                   o_push,
    output sdbw_pkg::t_seg_word    o_push_data,
    input  logic                   i_full
);

    logic                  en;
    logic [3:0]            r_vld;

    logic [1:0]            r_s0_mode;
    sdbw_pkg::t_seg_word   r_s0_seg;
    logic [15:0]           r_s0_value;
    logic [7:0]            r_s0_min;
    logic [7:0]            r_s0_sec;
    logic                  r_s0_colon;

    logic [1:0]            r_s1_mode;
    sdbw_pkg::t_seg_word   r_s1_seg;
    logic                  r_s1_colon;
    logic [15:0]           r_s1_value;
    logic [12:0]           r_s1_q1;
    logic [7:0]            r_s1_min;
    logic [4:0]            r_s1_qm;
    logic [7:0]            r_s1_sec;
    logic [4:0]            r_s1_qs;

    logic [1:0]            r_s2_mode;
    sdbw_pkg::t_seg_word   r_s2_seg;
    logic                  r_s2_colon;
    logic [3:0]            r_s2_d0;
    logic [12:0]           r_s2_q1;
    logic [9:0]            r_s2_q2;
    logic [3:0][3:0]       r_s2_tdig;

    logic [1:0]            r_s3_mode;
    sdbw_pkg::t_seg_word   r_s3_seg;
    logic                  r_s3_colon;
    logic [3:0]            r_s3_d0;
    logic [3:0]            r_s3_d1;
    logic [9:0]            r_s3_q2;
    logic [6:0]            r_s3_q3;
    logic [3:0][3:0]       r_s3_tdig;

    logic [12:0]           n_q1;
    logic [4:0]            n_qm;
    logic [4:0]            n_qs;
    logic [15:0]           n_d0_full;
    logic [12:0]           n_q2_full;
    logic [7:0]            n_m1_full;
    logic [7:0]            n_s1_full;
    logic [3:0][3:0]       n_tdig;
    logic [12:0]           n_d1_full;
    logic [12:0]           n_q3_full;
    logic [9:0]            n_d2_full;
    logic [3:0]            n_d3;
    sdbw_pkg::t_seg_word   n_seg;

    // whole pipe moves together; it only holds when the tail cannot enter the queue
    assign en         = !r_vld[3] || !i_full;
    assign o_in_ready = en;
    assign o_push     = r_vld[3] && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[2:0], i_in_valid};
        end
    end

    // stage 1: first tenth of the number, tens of minutes and seconds
    always_comb begin
        n_q1 = sdbw_pkg::div10_u16(r_s0_value);
        n_qm = sdbw_pkg::div10_u8(r_s0_min);
        n_qs = sdbw_pkg::div10_u8(r_s0_sec);
    end

    // stage 2: units digit, next tenth, time digits
    always_comb begin
        n_d0_full = r_s1_value - 16'(r_s1_q1) * 16'd10;
        n_q2_full = sdbw_pkg::div10_u16(16'(r_s1_q1));
        n_m1_full = r_s1_min - 8'(r_s1_qm) * 8'd10;
        n_s1_full = r_s1_sec - 8'(r_s1_qs) * 8'd10;
        n_tdig[0] = sdbw_pkg::mod10_small(7'(r_s1_qm));
        n_tdig[1] = n_m1_full[3:0];
        n_tdig[2] = sdbw_pkg::mod10_small(7'(r_s1_qs));
        n_tdig[3] = n_s1_full[3:0];
    end

    // stage 3: tens digit and thousands quotient
    always_comb begin
        n_d1_full = r_s2_q1 - 13'(r_s2_q2) * 13'd10;
        n_q3_full = sdbw_pkg::div10_u16(16'(r_s2_q2));
    end

    // stage 4: hundreds and thousands digits, glyphs and mode select
    always_comb begin
        n_d2_full = r_s3_q2 - 10'(r_s3_q3) * 10'd10;
        n_d3      = sdbw_pkg::mod10_small(r_s3_q3);
        unique case (r_s3_mode)
            sdbw_pkg::MODE_RAW: begin
                n_seg = r_s3_seg;
            end
            sdbw_pkg::MODE_NUMBER: begin
                n_seg[0] = sdbw_pkg::digit_glyph(n_d3);
                n_seg[1] = sdbw_pkg::digit_glyph(n_d2_full[3:0]);
                n_seg[2] = sdbw_pkg::digit_glyph(r_s3_d1);
                n_seg[3] = sdbw_pkg::digit_glyph(r_s3_d0);
            end
            sdbw_pkg::MODE_TIME: begin
                n_seg[0] = sdbw_pkg::digit_glyph(r_s3_tdig[0]);
                n_seg[1] = sdbw_pkg::digit_glyph(r_s3_tdig[1])
                           | (r_s3_colon ? sdbw_pkg::COLON_BIT : 8'h00);
                n_seg[2] = sdbw_pkg::digit_glyph(r_s3_tdig[2]);
                n_seg[3] = sdbw_pkg::digit_glyph(r_s3_tdig[3]);
            end
            default: begin
                n_seg = sdbw_pkg::FAULT_PATTERN;
            end
        endcase
    end

    assign o_push_data = n_seg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_mode  <= i_mode;
            r_s0_seg   <= {i_seg3, i_seg2, i_seg1, i_seg0};
            r_s0_value <= i_value;
            r_s0_min   <= i_minutes;
            r_s0_sec   <= i_seconds;
            r_s0_colon <= i_colon;

            r_s1_mode  <= r_s0_mode;
            r_s1_seg   <= r_s0_seg;
            r_s1_colon <= r_s0_colon;
            r_s1_value <= r_s0_value;
            r_s1_q1    <= n_q1;
            r_s1_min   <= r_s0_min;
            r_s1_qm    <= n_qm;
            r_s1_sec   <= r_s0_sec;
            r_s1_qs    <= n_qs;

            r_s2_mode  <= r_s1_mode;
            r_s2_seg   <= r_s1_seg;
            r_s2_colon <= r_s1_colon;
            r_s2_d0    <= n_d0_full[3:0];
            r_s2_q1    <= r_s1_q1;
            r_s2_q2    <= n_q2_full[9:0];
            r_s2_tdig  <= n_tdig;

            r_s3_mode  <= r_s2_mode;
            r_s3_seg   <= r_s2_seg;
            r_s3_colon <= r_s2_colon;
            r_s3_d0    <= r_s2_d0;
            r_s3_d1    <= n_d1_full[3:0];
            r_s3_q2    <= r_s2_q2;
            r_s3_q3    <= n_q3_full[6:0];
            r_s3_tdig  <= r_s2_tdig;
        end
    end

endmodule

>>> rtl/core/sdbw_fifo.sv
// small queue of segment words between the front end and the bus sequencer
module sdbw_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  sdbw_pkg::t_seg_word    i_data,
    output logic                   o_full,
    input  logic                   i_pop,
    output sdbw_pkg::t_seg_word    o_head,
    output logic                   o_empty
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    sdbw_pkg::t_seg_word r_mem [DEPTH];
    logic [PtrW-1:0]     r_wr_ptr;
    logic [PtrW-1:0]     r_rd_ptr;
    logic [CntW-1:0]     r_count;

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/sdbw_back.sv
// bus sequencer: drops unchanged updates, keeps the shown-segment cache, sends the byte frames
module sdbw_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sdbw_pkg::t_cfg         i_cfg,
    input  sdbw_pkg::t_seg_word    i_head,
    input  logic                   i_empty,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [7:0]             o_bus_byte,
    output logic                   o_frame_start,
    output logic                   o_frame_end,
    output logic                   o_last
);

    sdbw_pkg::t_back_state r_state;
    sdbw_pkg::t_back_state n_state;
    logic [2:0]            r_idx;
    sdbw_pkg::t_seg_word   r_cur;
    sdbw_pkg::t_seg_word   r_shown;

    logic                  r_out_valid;
    logic [7:0]            r_bus_byte;
    logic                  r_frame_start;
    logic                  r_frame_end;
    logic                  r_last;

    logic                  load_out;
    logic                  finishing;
    logic                  can_take;
    logic                  changed;
    logic                  start_update;
    logic [1:0]            seg_sel;
    logic [2:0]            seg_off;
    logic [7:0]            n_byte;
    logic                  n_start;
    logic                  n_end;
    logic                  n_last;

    assign load_out     = (r_state == sdbw_pkg::ST_SEND) && (!r_out_valid || i_out_ready);
    assign finishing    = load_out && (r_idx == sdbw_pkg::IDX_DISP_CMD);
    assign can_take     = (r_state == sdbw_pkg::ST_IDLE) || finishing;
    assign changed      = (i_head != r_shown);
    // an unchanged word is popped and dropped
    assign o_pop        = can_take && !i_empty;
    assign start_update = o_pop && changed;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sdbw_pkg::ST_IDLE: begin
                if (start_update) begin
                    n_state = sdbw_pkg::ST_SEND;
                end
            end
            sdbw_pkg::ST_SEND: begin
                if (finishing && !start_update) begin
                    n_state = sdbw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sdbw_pkg::ST_IDLE;
            end
        endcase
    end

    assign seg_off = r_idx - sdbw_pkg::IDX_SEG0;
    assign seg_sel = seg_off[1:0];

    always_comb begin
        n_byte  = r_cur[seg_sel];
        n_start = 1'b0;
        n_end   = 1'b0;
        n_last  = 1'b0;
        unique case (r_idx) inside
            sdbw_pkg::IDX_DATA_CMD: begin
                n_byte  = i_cfg.set_data_command;
                n_start = 1'b1;
                n_end   = 1'b1;
            end
            sdbw_pkg::IDX_ADDR_CMD: begin
                n_byte  = i_cfg.address_command;
                n_start = 1'b1;
            end
            sdbw_pkg::IDX_SEG0, sdbw_pkg::IDX_SEG1, sdbw_pkg::IDX_SEG2: begin
                n_byte = r_cur[seg_sel];
            end
            sdbw_pkg::IDX_SEG3: begin
                n_byte = r_cur[seg_sel];
                n_end  = 1'b1;
            end
            sdbw_pkg::IDX_DISP_CMD: begin
                n_byte  = i_cfg.display_command | sdbw_pkg::DISP_ON_BIT
                          | {5'b0, i_cfg.brightness};
                n_start = 1'b1;
                n_end   = 1'b1;
                n_last  = 1'b1;
            end
            default: begin
                n_byte = r_cur[seg_sel];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sdbw_pkg::ST_IDLE;
            r_idx       <= sdbw_pkg::IDX_DATA_CMD;
            r_shown     <= sdbw_pkg::BLANK_CACHE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (start_update) begin
                r_idx   <= sdbw_pkg::IDX_DATA_CMD;
                r_shown <= i_head;
            end else if (load_out) begin
                r_idx <= r_idx + 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_update) begin
            r_cur <= i_head;
        end
        if (load_out) begin
            r_bus_byte    <= n_byte;
            r_frame_start <= n_start;
            r_frame_end   <= n_end;
            r_last        <= n_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_bus_byte    = r_bus_byte;
    assign o_frame_start = r_frame_start;
    assign o_frame_end   = r_frame_end;
    assign o_last        = r_last;

endmodule

>>> rtl/core/segment_display_bus_writer.sv
// top level of the segment display bus writer: config registers, front end, queue, sequencer
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------------------
//  request  | i_in_valid / o_in_ready   | i_mode i_seg0..3 i_value i_minutes i_seconds i_colon
//  bus byte | o_out_valid / i_out_ready | o_bus_byte o_frame_start o_frame_end o_last
//  config   | i_cfg_we (no wait)        | i_cfg_addr i_cfg_wdata
//
// a request passes registers s0..s3 into the queue; the front end takes one per cycle
// unless a full queue holds its pipe; an update that changes the display sends seven bytes,
// one per cycle from the sequencer's byte counter unless stalled; unchanged ones send none
// synchronous active-low reset; shown-segment cache resets to all 0xFF, no clearing pass
// a stalled bus byte holds the sequencer; the queue then fills and the front end stalls
module segment_display_bus_writer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_seg0,
    input  logic [7:0]  i_seg1,
    input  logic [7:0]  i_seg2,
    input  logic [7:0]  i_seg3,
    input  logic [15:0] i_value,
    input  logic [7:0]  i_minutes,
    input  logic [7:0]  i_seconds,
    input  logic        i_colon,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_bus_byte,
    output logic        o_frame_start,
    output logic        o_frame_end,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata
);

    sdbw_pkg::t_cfg      r_cfg;
    logic                fifo_push;
    logic                fifo_full;
    logic                fifo_pop;
    logic                fifo_empty;
    sdbw_pkg::t_seg_word push_data;
    sdbw_pkg::t_seg_word fifo_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.brightness       <= 3'd7;
            r_cfg.set_data_command <= 8'h40;
            r_cfg.address_command  <= 8'hC0;
            r_cfg.display_command  <= 8'h80;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                sdbw_pkg::CFG_BRIGHTNESS: r_cfg.brightness       <= i_cfg_wdata[2:0];
                sdbw_pkg::CFG_DATA_CMD:   r_cfg.set_data_command <= i_cfg_wdata;
                sdbw_pkg::CFG_ADDR_CMD:   r_cfg.address_command  <= i_cfg_wdata;
                sdbw_pkg::CFG_DISP_CMD:   r_cfg.display_command  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    sdbw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_seg0      (i_seg0),
        .i_seg1      (i_seg1),
        .i_seg2      (i_seg2),
        .i_seg3      (i_seg3),
        .i_value     (i_value),
        .i_minutes   (i_minutes),
        .i_seconds   (i_seconds),
        .i_colon     (i_colon),
        .o_push      (fifo_push),
        .o_push_data (push_data),
        .i_full      (fifo_full)
    );

    sdbw_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fifo_push),
        .i_data  (push_data),
        .o_full  (fifo_full),
        .i_pop   (fifo_pop),
        .o_head  (fifo_head),
        .o_empty (fifo_empty)
    );

    sdbw_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_head        (fifo_head),
        .i_empty       (fifo_empty),
        .o_pop         (fifo_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_bus_byte    (o_bus_byte),
        .o_frame_start (o_frame_start),
        .o_frame_end   (o_frame_end),
        .o_last        (o_last)
    );

`ifndef ASSERT_OFF
    // the closing byte is the display command, which always carries the display-on bit
    a_last_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> o_frame_start && o_frame_end && o_bus_byte[3])
        else $error("last byte of an update is not a display command frame");

    // after the last byte moves, the next byte shown opens a new frame
    a_next_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_last |=> !o_out_valid || o_frame_start)
        else $error("update did not restart with a framed command byte");

    // reset leaves no byte pending and an empty queue
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && fifo_empty)
        else $error("reset did not clear output and queue");

    // the queue never reports full and empty together
    a_queue_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fifo_full && fifo_empty))
        else $error("queue full and empty at once");
`endif

endmodule

>>> dv/segment_display_bus_writer_tb.sv
// self-checking testbench for the segment display bus writer: display requests in, bus bytes checked
`timescale 1ns / 100ps

module segment_display_bus_writer_tb;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PRESSURE_HOLD = 400;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  seg0;
        logic [7:0]  seg1;
        logic [7:0]  seg2;
        logic [7:0]  seg3;
        logic [15:0] value;
        logic [7:0]  minutes;
        logic [7:0]  seconds;
        logic        colon;
    } t_request;

    typedef struct packed {
        logic [7:0] bus_byte;
        logic       frame_start;
        logic       frame_end;
        logic       last;
    } t_bus_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_mode = '0;
    logic [7:0]  i_seg0 = '0;
    logic [7:0]  i_seg1 = '0;
    logic [7:0]  i_seg2 = '0;
    logic [7:0]  i_seg3 = '0;
    logic [15:0] i_value = '0;
    logic [7:0]  i_minutes = '0;
    logic [7:0]  i_seconds = '0;
    logic        i_colon = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b1;
    logic [7:0]  o_bus_byte;
    logic        o_frame_start;
    logic        o_frame_end;
    logic        o_last;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_addr = '0;
    logic [7:0]  i_cfg_wdata = '0;

    segment_display_bus_writer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_seg0        (i_seg0),
        .i_seg1        (i_seg1),
        .i_seg2        (i_seg2),
        .i_seg3        (i_seg3),
        .i_value       (i_value),
        .i_minutes     (i_minutes),
        .i_seconds     (i_seconds),
        .i_colon       (i_colon),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_bus_byte    (o_bus_byte),
        .o_frame_start (o_frame_start),
        .o_frame_end   (o_frame_end),
        .o_last        (o_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state: what the display shows and the live register values
    sdbw_pkg::t_seg_word model_shown = {8'hFF, 8'hFF, 8'hFF, 8'hFF};
    sdbw_pkg::t_cfg      model_cfg = '{brightness: 3'd7, set_data_command: 8'h40,
                                       address_command: 8'hC0, display_command: 8'h80};
    t_bus_result pending_bytes[$];
    t_request    last_request = '0;

    const logic [7:0] decimal_glyph [10] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                                              8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};

    int cycle_count = 0;
    int error_count = 0;
    int requests_sent = 0;
    int update_count = 0;
    int unchanged_count = 0;
    int bytes_checked = 0;
    int register_writes = 0;
    int settings_used = 1;

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int hold_request = 0;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return $urandom_range(1, 3);
        else if (roll < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_request request_of(input logic [1:0] mode, input logic [7:0] s0,
                                            input logic [7:0] s1, input logic [7:0] s2,
                                            input logic [7:0] s3, input logic [15:0] value,
                                            input logic [7:0] minutes, input logic [7:0] seconds,
                                            input logic colon);
        t_request r;
        r.mode = mode;
        r.seg0 = s0;
        r.seg1 = s1;
        r.seg2 = s2;
        r.seg3 = s3;
        r.value = value;
        r.minutes = minutes;
        r.seconds = seconds;
        r.colon = colon;
        return r;
    endfunction

    function automatic sdbw_pkg::t_seg_word form_segments(input t_request r);
        sdbw_pkg::t_seg_word segs;
        int v;
        int m;
        int s;
        v = r.value;
        m = r.minutes;
        s = r.seconds;
        case (r.mode)
            sdbw_pkg::MODE_RAW: begin
                segs[0] = r.seg0;
                segs[1] = r.seg1;
                segs[2] = r.seg2;
                segs[3] = r.seg3;
            end
            sdbw_pkg::MODE_NUMBER: begin
                segs[0] = decimal_glyph[(v / 1000) % 10];
                segs[1] = decimal_glyph[(v / 100) % 10];
                segs[2] = decimal_glyph[(v / 10) % 10];
                segs[3] = decimal_glyph[v % 10];
            end
            sdbw_pkg::MODE_TIME: begin
                segs[0] = decimal_glyph[(m / 10) % 10];
                segs[1] = decimal_glyph[m % 10];
                segs[2] = decimal_glyph[(s / 10) % 10];
                segs[3] = decimal_glyph[s % 10];
                if (r.colon)
                    segs[1] = segs[1] | sdbw_pkg::COLON_BIT;
            end
            default: begin
                segs[0] = 8'h71;
                segs[1] = 8'h77;
                segs[2] = 8'h3E;
                segs[3] = 8'h38;
            end
        endcase
        return segs;
    endfunction

    function automatic t_bus_result bus_entry(input logic [7:0] b, input logic st,
                                              input logic en, input logic lst);
        t_bus_result e;
        e.bus_byte = b;
        e.frame_start = st;
        e.frame_end = en;
        e.last = lst;
        return e;
    endfunction

    // queues the seven bus bytes of an update, or nothing when the display is unchanged
    function automatic void predict_bus_bytes(input t_request r);
        sdbw_pkg::t_seg_word segs;
        segs = form_segments(r);
        if (segs == model_shown) begin
            unchanged_count++;
            return;
        end
        model_shown = segs;
        update_count++;
        pending_bytes.push_back(bus_entry(model_cfg.set_data_command, 1'b1, 1'b1, 1'b0));
        pending_bytes.push_back(bus_entry(model_cfg.address_command, 1'b1, 1'b0, 1'b0));
        for (int i = 0; i < sdbw_pkg::DIGIT_COUNT; i++)
            pending_bytes.push_back(bus_entry(segs[i], 1'b0, i == sdbw_pkg::DIGIT_COUNT - 1,
                                              1'b0));
        pending_bytes.push_back(bus_entry(model_cfg.display_command | sdbw_pkg::DISP_ON_BIT |
                                          8'(model_cfg.brightness), 1'b1, 1'b1, 1'b1));
    endfunction

    function automatic t_request random_request();
        t_request r;
        // a repeat of the previous request should leave the display alone
        if ($urandom_range(0, 99) < 20)
            return last_request;
        r.mode = 2'($urandom_range(0, 3));
        r.seg0 = 8'($urandom);
        r.seg1 = 8'($urandom);
        r.seg2 = 8'($urandom);
        r.seg3 = 8'($urandom);
        r.value = ($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'($urandom_range(0, 9999));
        r.minutes = ($urandom_range(0, 1) == 1) ? 8'($urandom) : 8'($urandom_range(0, 99));
        r.seconds = ($urandom_range(0, 1) == 1) ? 8'($urandom) : 8'($urandom_range(0, 59));
        r.colon = 1'($urandom);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        $display("mismatch at cycle %0d: %s expected %02h got %02h", cycle_count, what, want,
                 got);
        error_count++;
    endtask

    // checks every bus byte transfer against the oldest pending byte
    always @(posedge i_clk) begin
        t_bus_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_bytes.size() == 0) begin
                report_mismatch("unexpected bus byte", 8'h00, o_bus_byte);
            end else begin
                want = pending_bytes.pop_front();
                if (o_bus_byte !== want.bus_byte)
                    report_mismatch("bus_byte", want.bus_byte, o_bus_byte);
                if (o_frame_start !== want.frame_start)
                    report_mismatch("frame_start", 8'(want.frame_start), 8'(o_frame_start));
                if (o_frame_end !== want.frame_end)
                    report_mismatch("frame_end", 8'(want.frame_end), 8'(o_frame_end));
                if (o_last !== want.last)
                    report_mismatch("last", 8'(want.last), 8'(o_last));
                bytes_checked++;
            end
        end
    end

    // bus side: random stalls, plus a long hold-off when one is requested
    always @(posedge i_clk) begin
        int stall_left;
        if (hold_request > 0) begin
            stall_left = hold_request;
            hold_request = 0;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (rx_idle_on && $urandom_range(0, 99) < 12)
                stall_left = pick_gap();
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles with %0d bus bytes pending", cycle_count,
                 pending_bytes.size());
        $display("FAIL");
        $finish;
    end

    // entered and left at a rising edge; valid stays high after the transfer
    task automatic send_request(input t_request r);
        int gap;
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 99) < 40)
            gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= r.mode;
        i_seg0 <= r.seg0;
        i_seg1 <= r.seg1;
        i_seg2 <= r.seg2;
        i_seg3 <= r.seg3;
        i_value <= r.value;
        i_minutes <= r.minutes;
        i_seconds <= r.seconds;
        i_colon <= r.colon;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        predict_bus_bytes(r);
        last_request = r;
        requests_sent++;
    endtask

    // unchanged requests leave nothing pending, so allow them to clear the pipeline too
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [7:0] index, input logic [7:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= index;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (index)
            sdbw_pkg::CFG_BRIGHTNESS: model_cfg.brightness = data[2:0];
            sdbw_pkg::CFG_DATA_CMD:   model_cfg.set_data_command = data;
            sdbw_pkg::CFG_ADDR_CMD:   model_cfg.address_command = data;
            sdbw_pkg::CFG_DISP_CMD:   model_cfg.display_command = data;
            default: ;
        endcase
        register_writes++;
    endtask

    task automatic write_settings(input logic [7:0] bright, input logic [7:0] data_cmd,
                                  input logic [7:0] addr_cmd, input logic [7:0] disp_cmd);
        wait_idle();
        write_register(sdbw_pkg::CFG_BRIGHTNESS, bright);
        write_register(sdbw_pkg::CFG_DATA_CMD, data_cmd);
        // an index past the last register must not disturb anything
        write_register(8'($urandom_range(4, 255)), 8'($urandom));
        write_register(sdbw_pkg::CFG_ADDR_CMD, addr_cmd);
        write_register(sdbw_pkg::CFG_DISP_CMD, disp_cmd);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic test_reset_cache();
        // all-blank raw request matches the cache straight out of reset
        send_request(request_of(sdbw_pkg::MODE_RAW,
                                8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'h0, 8'h0, 8'h0, 1'b0));
        send_request(request_of(sdbw_pkg::MODE_RAW,
                                8'h00, 8'h00, 8'h00, 8'h00, 16'hFFFF, 8'hFF, 8'hFF, 1'b1));
        send_request(request_of(sdbw_pkg::MODE_RAW,
                                8'h00, 8'h00, 8'h00, 8'h00, 16'h0, 8'h0, 8'h0, 1'b0));
        send_request(request_of(sdbw_pkg::MODE_RAW,
                                8'hFF, 8'h00, 8'h80, 8'h7F, 16'h0, 8'h0, 8'h0, 1'b0));
    endtask

    task automatic test_directed_modes();
        send_request(request_of(sdbw_pkg::MODE_NUMBER,
                                8'h0, 8'h0, 8'h0, 8'h0, 16'd0, 8'h0, 8'h0, 1'b0));
        send_request(request_of(sdbw_pkg::MODE_NUMBER,
                                8'h0, 8'h0, 8'h0, 8'h0, 16'd9999, 8'h0, 8'h0, 1'b0));
        send_request(request_of(sdbw_pkg::MODE_NUMBER,
                                8'h0, 8'h0, 8'h0, 8'h0, 16'd10000, 8'h0, 8'h0, 1'b0));
        send_request(request_of(sdbw_pkg::MODE_NUMBER,
                                8'h0, 8'h0, 8'h0, 8'h0, 16'd65535, 8'h0, 8'h0, 1'b0));
        send_request(request_of(sdbw_pkg::MODE_NUMBER,
                                8'hA5, 8'h5A, 8'hFF, 8'h01, 16'd1234, 8'd77, 8'd88, 1'b1));
        send_request(request_of(sdbw_pkg::MODE_TIME,
                                8'h0, 8'h0, 8'h0, 8'h0, 16'h0, 8'd0, 8'd0, 1'b0));
        // colon alone changes the display
        send_request(request_of(sdbw_pkg::MODE_TIME,
                                8'h0, 8'h0, 8'h0, 8'h0, 16'h0, 8'd0, 8'd0, 1'b1));
        send_request(request_of(sdbw_pkg::MODE_TIME,
                                8'h0, 8'h0, 8'h0, 8'h0, 16'h0, 8'd99, 8'd59, 1'b1));
        send_request(request_of(sdbw_pkg::MODE_TIME,
                                8'h0, 8'h0, 8'h0, 8'h0, 16'h0, 8'd255, 8'd255, 1'b0));
        send_request(request_of(sdbw_pkg::MODE_TIME,
                                8'h0, 8'h0, 8'h0, 8'h0, 16'h0, 8'd100, 8'd200, 1'b1));
        send_request(request_of(sdbw_pkg::MODE_FAULT,
                                8'h0, 8'h0, 8'h0, 8'h0, 16'h0, 8'h0, 8'h0, 1'b0));
        send_request(request_of(sdbw_pkg::MODE_FAULT,
                                8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 1'b1));
        // raw bytes equal to the fault pattern are no change either
        send_request(request_of(sdbw_pkg::MODE_RAW,
                                8'h71, 8'h77, 8'h3E, 8'h38, 16'h0, 8'h0, 8'h0, 1'b0));
        send_request(request_of(sdbw_pkg::MODE_RAW,
                                8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'h0, 8'h0, 8'h0, 1'b0));
        send_request(request_of(sdbw_pkg::MODE_NUMBER,
                                8'h0, 8'h0, 8'h0, 8'h0, 16'd0, 8'h0, 8'h0, 1'b0));
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) send_request(random_request());
    endtask

    task automatic test_register_extremes();
        // brightness above three bits is masked down
        write_settings(8'hF8, 8'h00, 8'h00, 8'h00);
        test_random_traffic(70);
        write_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        test_random_traffic(70);
        repeat (2) begin
            write_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            test_random_traffic(40);
        end
    endtask

    task automatic test_back_pressure();
        wait_idle();
        hold_request = PRESSURE_HOLD;
        // every request here changes the display, so the block has to back up
        for (int i = 0; i < 25; i++)
            send_request(request_of(sdbw_pkg::MODE_NUMBER, 8'h0, 8'h0, 8'h0, 8'h0,
                                    16'(1000 + i * 7), 8'h0, 8'h0, 1'b0));
    endtask

    task automatic test_back_to_back();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random_traffic(50);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_cache();
        test_directed_modes();
        test_random_traffic(40);
        test_register_extremes();
        test_back_pressure();
        test_back_to_back();
        i_in_valid <= 1'b0;
        for (int n = 0; n < 20000 && pending_bytes.size() != 0; n++)
            @(posedge i_clk);
        if (pending_bytes.size() != 0) begin
            $display("%0d bus bytes never arrived", pending_bytes.size());
            error_count++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d requests: %0d display updates, %0d left unchanged, %0d bytes checked",
                 requests_sent, update_count, unchanged_count, bytes_checked);
        $display("%0d register writes over %0d settings, one %0d-cycle bus hold-off, %0d errors",
                 register_writes, settings_used, PRESSURE_HOLD, error_count);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
